FILE: sv/bfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types, codes and helper functions of the bitmap first-fit allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

	// Default pool sizes
	localparam int INODE_COUNT_DEF = 1024;
	localparam int BLK_COUNT_DEF   = 4096;

	// Entries reserved by the formatted layout
	localparam int INODE_RESERVED = 2;
	localparam int BLOCK_RESERVED = 10;

	// Bitmap word geometry
	localparam int WORD_W = 64;
	localparam int BIT_W  = 6;
	localparam int WIDX_W = 6;
	localparam int MAXW   = 64;
	localparam int IDX_W  = 12;
	localparam int CNT_W  = 13;
	localparam int STAT_W = 2;

	// Request codes
	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_FREE    = 1'b1;
	localparam logic POOL_INODE = 1'b0;
	localparam logic POOL_BLOCK = 1'b1;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DISABLED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd3;

	typedef struct packed {
		logic             opcode;
		logic             pool;
		logic [IDX_W-1:0] entry_index;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  granted_index;
	} rsp_t;

	// Lowest clear bit of a word
	typedef struct packed {
		logic             hit;
		logic [BIT_W-1:0] pos;
	} ffz_t;

	// Summary flag update from the read-modify-write stage
	typedef struct packed {
		logic              we;
		logic              pool;
		logic [WIDX_W-1:0] widx;
		logic              full;
	} sum_upd_t;

	// Bitmap RAM access for one word
	typedef struct packed {
		logic              rd;
		logic              wr;
		logic              pool;
		logic [WIDX_W-1:0] widx;
	} ram_req_t;

	// Find the lowest clear bit of a word
	function automatic ffz_t ffz(logic [WORD_W-1:0] w);
		ffz_t r;
		r.hit = 1'b0;
		r.pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) begin
				r.hit = 1'b1;
				r.pos = BIT_W'(i);
			end
		end
		return r;
	endfunction

	// Word contents after format: reserved entries and entries past the pool are set
	function automatic logic [WORD_W-1:0] reset_word(logic pool, logic [WIDX_W-1:0] widx,
			int icount, int bcount);
		logic [WORD_W-1:0] r;
		int                n;
		int                rsv;
		int                cnt;
		rsv = (pool == POOL_BLOCK) ? BLOCK_RESERVED : INODE_RESERVED;
		cnt = (pool == POOL_BLOCK) ? bcount : icount;
		for (int b = 0; b < WORD_W; b++) begin
			n    = int'(widx) * WORD_W + b;
			r[b] = (n < rsv) || (n >= cnt);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: sv/bfa_summary.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_summary
// One full flag per bitmap word of each pool, with a search for the lowest
// word that still has a clear bit.
// ----------------------------------------------------------------------------
module bfa_summary #(
	parameter int INODE_COUNT = bfa_pkg::INODE_COUNT_DEF,
	parameter int BLK_COUNT   = bfa_pkg::BLK_COUNT_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  qpool,
	output bfa_pkg::ffz_t        qword,
	input  wire bfa_pkg::sum_upd_t upd
);

	localparam int IW = (INODE_COUNT + bfa_pkg::WORD_W - 1) / bfa_pkg::WORD_W;
	localparam int BW = (BLK_COUNT + bfa_pkg::WORD_W - 1) / bfa_pkg::WORD_W;

	logic [bfa_pkg::MAXW-1:0] ifull;
	logic [bfa_pkg::MAXW-1:0] bfull;

	// Flags of existing words; words past the pool read as full
	for (genvar w = 0; w < bfa_pkg::MAXW; w++) begin : g_flag
		if (w < IW) begin : g_ion
			logic ifull_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					ifull_q <= &bfa_pkg::reset_word(bfa_pkg::POOL_INODE,
						bfa_pkg::WIDX_W'(w), INODE_COUNT, BLK_COUNT);
				end else if (upd.we && upd.pool == bfa_pkg::POOL_INODE &&
						upd.widx == bfa_pkg::WIDX_W'(w)) begin
					ifull_q <= upd.full;
				end
			end
			assign ifull[w] = ifull_q;
		end else begin : g_ioff
			assign ifull[w] = 1'b1;
		end
		if (w < BW) begin : g_bon
			logic bfull_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					bfull_q <= &bfa_pkg::reset_word(bfa_pkg::POOL_BLOCK,
						bfa_pkg::WIDX_W'(w), INODE_COUNT, BLK_COUNT);
				end else if (upd.we && upd.pool == bfa_pkg::POOL_BLOCK &&
						upd.widx == bfa_pkg::WIDX_W'(w)) begin
					bfull_q <= upd.full;
				end
			end
			assign bfull[w] = bfull_q;
		end else begin : g_boff
			assign bfull[w] = 1'b1;
		end
	end

	// Pick the lowest word with room in the queried pool
	assign qword = bfa_pkg::ffz((qpool == bfa_pkg::POOL_BLOCK) ? bfull : ifull);

endmodule
`default_nettype wire

FILE: sv/bfa_map_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_map_ram
// Bitmap word store for both pools, one read or write port use per cycle,
// registered read data. Words never written read as the formatted layout.
// ----------------------------------------------------------------------------
module bfa_map_ram #(
	parameter int INODE_COUNT = bfa_pkg::INODE_COUNT_DEF,
	parameter int BLK_COUNT   = bfa_pkg::BLK_COUNT_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire bfa_pkg::ram_req_t       req,
	input  wire [bfa_pkg::WORD_W-1:0]    wdata,
	output logic [bfa_pkg::WORD_W-1:0]   rdata
);

	localparam int IW     = (INODE_COUNT + bfa_pkg::WORD_W - 1) / bfa_pkg::WORD_W;
	localparam int BW     = (BLK_COUNT + bfa_pkg::WORD_W - 1) / bfa_pkg::WORD_W;
	localparam int DEPTH  = IW + BW;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [bfa_pkg::WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]           vld_q;
	logic [ADDR_W-1:0]          addr;
	logic [bfa_pkg::WORD_W-1:0] rst_word;

	// Inode words first, block words after them
	assign addr = (req.pool == bfa_pkg::POOL_BLOCK) ?
		ADDR_W'(IW) + ADDR_W'(req.widx) : ADDR_W'(req.widx);

	assign rst_word = bfa_pkg::reset_word(req.pool, req.widx, INODE_COUNT, BLK_COUNT);

	// Mark words once written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.wr) begin
			vld_q[addr] <= 1'b1;
		end
	end

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[addr] <= wdata;
		end
		if (req.rd) begin
			rdata <= vld_q[addr] ? mem[addr] : rst_word;
		end
	end

endmodule
`default_nettype wire

FILE: sv/bitmap_first_fit_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator
// First-fit allocator over an inode bitmap and a data block bitmap.
//
// Each request item allocates the lowest free entry of a pool or frees a
// given entry, and yields one response item. The bitmaps are kept as 64-bit
// words in one synchronous RAM; a flag per word marks full words, so an
// allocation picks its word at accept, then reads, modifies and writes that
// word back. One item is handled at a time: accept, RAM read, modify and
// write, and response load, which waits while the response side stalls; a
// rejected request skips the RAM steps. After reset the maps hold the
// formatted layout with no clearing pass.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator #(
	parameter int INODE_COUNT = bfa_pkg::INODE_COUNT_DEF,
	parameter int BLK_COUNT   = bfa_pkg::BLK_COUNT_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire                 cfg_wdata,
	input  wire                 req_valid,
	output logic                req_stall,
	input  wire bfa_pkg::req_t  req,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output bfa_pkg::rsp_t       rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_MOD  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]                   state_q;
	logic                         enabled_q;
	logic                         op_q;
	logic                         pool_q;
	logic [bfa_pkg::WIDX_W-1:0]   widx_q;
	logic [bfa_pkg::BIT_W-1:0]    bit_q;
	bfa_pkg::rsp_t                res_q;
	logic                         rsp_valid_q;
	bfa_pkg::rsp_t                rsp_q;

	bfa_pkg::ffz_t                qword;
	bfa_pkg::sum_upd_t            upd;
	bfa_pkg::ram_req_t            ram_req;
	logic [bfa_pkg::WORD_W-1:0]   rdata;
	logic [bfa_pkg::WORD_W-1:0]   new_word;
	bfa_pkg::ffz_t                wbit;
	logic                         accept;
	logic                         range_bad;
	logic [bfa_pkg::CNT_W-1:0]    pool_cnt;

	bfa_summary #(
		.INODE_COUNT (INODE_COUNT),
		.BLK_COUNT   (BLK_COUNT)
	) u_summary (
		.clk    (clk),
		.arst_n (arst_n),
		.qpool  (req.pool),
		.qword  (qword),
		.upd    (upd)
	);

	bfa_map_ram #(
		.INODE_COUNT (INODE_COUNT),
		.BLK_COUNT   (BLK_COUNT)
	) u_map_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ram_req),
		.wdata  (new_word),
		.rdata  (rdata)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Range check for a free
	assign pool_cnt  = (req.pool == bfa_pkg::POOL_BLOCK) ?
		bfa_pkg::CNT_W'(BLK_COUNT) : bfa_pkg::CNT_W'(INODE_COUNT);
	assign range_bad = ({1'b0, req.entry_index} >= pool_cnt) ||
		(req.pool == bfa_pkg::POOL_INODE && req.entry_index == '0);

	// Modify the word read back
	assign wbit = bfa_pkg::ffz(rdata);
	always_comb begin
		if (op_q == bfa_pkg::OP_ALLOC) begin
			new_word = rdata | (bfa_pkg::WORD_W'(1) << wbit.pos);
		end else begin
			new_word = rdata & ~(bfa_pkg::WORD_W'(1) << bit_q);
		end
	end

	assign ram_req.rd   = (state_q == ST_RD);
	assign ram_req.wr   = (state_q == ST_MOD);
	assign ram_req.pool = pool_q;
	assign ram_req.widx = widx_q;

	assign upd.we   = (state_q == ST_MOD);
	assign upd.pool = pool_q;
	assign upd.widx = widx_q;
	assign upd.full = &new_word;

	// Hold the enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg_we) begin
			enabled_q <= cfg_wdata;
		end
	end

	// Sequence one item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!enabled_q) begin
							state_q <= ST_OUT;
						end else if (req.opcode == bfa_pkg::OP_ALLOC) begin
							state_q <= qword.hit ? ST_RD : ST_OUT;
						end else begin
							state_q <= range_bad ? ST_OUT : ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the request and build the result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			op_q   <= req.opcode;
			pool_q <= req.pool;
			bit_q  <= req.entry_index[bfa_pkg::BIT_W-1:0];
			res_q.granted_index <= '0;
			if (req.opcode == bfa_pkg::OP_ALLOC) begin
				widx_q <= qword.pos;
			end else begin
				widx_q <= req.entry_index[bfa_pkg::IDX_W-1:bfa_pkg::BIT_W];
			end
			if (!enabled_q) begin
				res_q.status <= bfa_pkg::STAT_DISABLED;
			end else if (req.opcode == bfa_pkg::OP_ALLOC) begin
				res_q.status <= qword.hit ? bfa_pkg::STAT_OK : bfa_pkg::STAT_FULL;
			end else begin
				res_q.status <= range_bad ? bfa_pkg::STAT_RANGE : bfa_pkg::STAT_OK;
			end
		end else if (state_q == ST_MOD && op_q == bfa_pkg::OP_ALLOC) begin
			res_q.granted_index <= {widx_q, wbit.pos};
		end
	end

	// Response register: load when free or being taken, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!rsp_valid_q || !rsp_stall)) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q <= res_q;
		end
	end

endmodule
`default_nettype wire
